>>> src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on clk, off during reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen.
`define CHK_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> src/pcc_pkg.sv
package pcc_pkg;

  localparam int MAX_LEN     = 16;
  localparam int CHARSET_MAX = 128;
  localparam int POS_W       = $clog2(MAX_LEN);
  localparam int SPOS_W      = $clog2(MAX_LEN + 1);
  localparam int TAB_AW      = $clog2(CHARSET_MAX);
  localparam int DIG_W       = TAB_AW;
  localparam int CHAR_W      = 8;
  localparam int CLEN_W      = 8;
  localparam int STEP_W      = 16;
  localparam int SUM_W       = 18;
  localparam int CNT_W       = $clog2(SUM_W + 1);

  // Register indexes on the config port
  localparam logic REG_CHARSET_LEN = 1'b0;
  localparam logic REG_STEP_SIZE   = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_CHAR = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_WRITE_PW  = 2'd2,
    OP_GENERATE  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_FILL,
    ST_WR,
    ST_GEN_CHK,
    ST_GEN_SUM,
    ST_GEN_DIV,
    ST_EMIT_BEGIN,
    ST_EMIT_DIG,
    ST_EMIT_TAB,
    ST_EMIT_OUT,
    ST_ONE_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [CLEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SUM_W-1:0]   quot;
    logic [DIG_W-1:0]   rem;
  } div_rsp_t;

  typedef struct packed {
    logic               push;
    logic [CHAR_W-1:0]  ch;
    logic [SPOS_W-1:0]  pos;
    logic               last;
    logic               ovf;
  } res_t;

endpackage

>>> src/password_candidate_counter.sv
// Channel  Handshake               Payload
// cmd      cmd_valid / cmd_ready   opcode, table_index, digit_position, char_value
// res      res_valid / res_ready   out_char, out_position, last, overflow
// apb      psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// Load charset and clear finish in the idle state. Write password character: a read
// and compare per charset entry searched, a write per digit zeroed left of the live
// part, then the digit write. Generate: a digit read and sum per live digit, an
// 18-step division per digit touched, then a digit and table read per character.
// Synchronous reset clears control state; charset memory is undefined until loaded.
// A stalled res transfer holds the controller; one result waits in the output register.
module password_candidate_counter import pcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [1:0]        opcode,
  input  logic [6:0]        table_index,
  input  logic [3:0]        digit_position,
  input  logic [7:0]        char_value,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [7:0]        out_char,
  output logic [4:0]        out_position,
  output logic              last,
  output logic              overflow,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CLEN_W-1:0] charset_len;
  logic [STEP_W-1:0] step_size;
  logic              slot_free;
  res_t              res;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Config registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset_len <= CLEN_W'(1);
      step_size   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_CHARSET_LEN: charset_len <= pwdata[CLEN_W-1:0];
        REG_STEP_SIZE:   step_size   <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CHARSET_LEN: prdata = 32'(charset_len);
      REG_STEP_SIZE:   prdata = 32'(step_size);
      default:         prdata = '0;
    endcase
  end

  // Output register
  assign slot_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res.push) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      out_char     <= res.ch;
      out_position <= res.pos;
      last         <= res.last;
      overflow     <= res.ovf;
    end
  end

  pcc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cmd_fire       (cmd_valid && cmd_ready),
    .cmd_ready      (cmd_ready),
    .opcode         (opcode),
    .table_index    (table_index),
    .digit_position (digit_position),
    .char_value     (char_value),
    .charset_len    (charset_len),
    .step_size      (step_size),
    .slot_free      (slot_free),
    .res            (res),
    .div_req        (div_req),
    .div_rsp        (div_rsp)
  );

  pcc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

>>> src/pcc_divider.sv
module pcc_divider import pcc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [SUM_W-1:0]  quot;
  logic [DIG_W-1:0]  rem;
  logic [CLEN_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [DIG_W:0]    shifted;
  logic              qbit;
  logic [DIG_W-1:0]  rem_next;

  // One restoring step: remainder stays below divisor, so DIG_W bits hold it
  always_comb begin
    shifted  = {rem, quot[SUM_W-1]};
    qbit     = (shifted >= dvs);
    rem_next = qbit ? DIG_W'(shifted - dvs) : shifted[DIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
      cnt  <= CNT_W'(SUM_W);
    end else if (busy) begin
      quot <= {quot[SUM_W-2:0], qbit};
      rem  <= rem_next;
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

>>> src/pcc_ctrl.sv
module pcc_ctrl import pcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_fire,
  output logic              cmd_ready,
  input  logic [1:0]        opcode,
  input  logic [TAB_AW-1:0] table_index,
  input  logic [POS_W-1:0]  digit_position,
  input  logic [CHAR_W-1:0] char_value,
  input  logic [CLEN_W-1:0] charset_len,
  input  logic [STEP_W-1:0] step_size,
  input  logic              slot_free,
  output res_t              res,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp
);

  // Storage
  logic [CHAR_W-1:0] table_mem [CHARSET_MAX];
  logic [DIG_W-1:0]  digit_mem [MAX_LEN];

  logic              tab_re, tab_we;
  logic [TAB_AW-1:0] tab_raddr, tab_waddr;
  logic [CHAR_W-1:0] tab_wdata, tab_rdata;
  logic              dig_re, dig_we;
  logic [POS_W-1:0]  dig_raddr, dig_waddr;
  logic [DIG_W-1:0]  dig_wdata, dig_rdata;

  state_t state, state_next;

  logic [TAB_AW-1:0] idx;
  logic [DIG_W-1:0]  found;
  logic [POS_W-1:0]  pos_l;
  logic [CHAR_W-1:0] ch_l;
  logic [SPOS_W-1:0] fill;
  logic [POS_W-1:0]  p;
  logic [SPOS_W-1:0] start;
  logic [SUM_W-1:0]  carry;
  logic [POS_W-1:0]  ei;
  logic              ovf_flag;

  logic [CLEN_W-1:0] len;
  logic              p_empty;
  logic              srch_hit, srch_end;
  logic              ei_last;

  always_ff @(posedge clk) begin
    if (tab_we) table_mem[tab_waddr] <= tab_wdata;
    if (tab_re) tab_rdata <= table_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (dig_we) digit_mem[dig_waddr] <= dig_wdata;
    if (dig_re) dig_rdata <= digit_mem[dig_raddr];
  end

  // Effective charset length, clamped to 1..CHARSET_MAX
  always_comb begin
    len = charset_len;
    if (charset_len == '0) len = CLEN_W'(1);
    if ({1'b0, charset_len} > (CLEN_W + 1)'(CHARSET_MAX)) len = CLEN_W'(CHARSET_MAX);
  end

  assign p_empty   = ({1'b0, p} < start);
  assign srch_hit  = (tab_rdata == ch_l);
  assign srch_end  = ({1'b0, idx} == CLEN_W'(len - CLEN_W'(1)));
  assign ei_last   = (ei == POS_W'(MAX_LEN - 1));
  assign cmd_ready = (state == ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          priority if (opcode == OP_WRITE_PW &&
                       {1'b0, digit_position} < SPOS_W'(MAX_LEN)) begin
            state_next = ST_SRCH_RD;
          end else if (opcode == OP_GENERATE) begin
            state_next = ST_GEN_CHK;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SRCH_RD:  state_next = ST_SRCH_CMP;
      ST_SRCH_CMP: state_next = (srch_hit || srch_end) ? ST_FILL : ST_SRCH_RD;
      ST_FILL:     if (fill >= start) state_next = ST_WR;
      ST_WR:       state_next = ST_IDLE;
      ST_GEN_CHK: begin
        if (!p_empty)         state_next = ST_GEN_SUM;
        else if (carry == '0) state_next = ST_EMIT_BEGIN;
        else                  state_next = ST_GEN_DIV;
      end
      ST_GEN_SUM:  state_next = ST_GEN_DIV;
      ST_GEN_DIV: begin
        if (div_rsp.done) begin
          priority if (div_rsp.quot == '0) state_next = ST_EMIT_BEGIN;
          else if (p == '0)                state_next = ST_ONE_OUT;
          else                             state_next = ST_GEN_CHK;
        end
      end
      ST_EMIT_BEGIN: state_next = (start >= SPOS_W'(MAX_LEN)) ? ST_ONE_OUT : ST_EMIT_DIG;
      ST_EMIT_DIG:   state_next = ST_EMIT_TAB;
      ST_EMIT_TAB:   state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (slot_free) state_next = ei_last ? ST_IDLE : ST_EMIT_DIG;
      end
      ST_ONE_OUT:    if (slot_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Memory ports, divider request and results
  always_comb begin
    tab_re    = 1'b0;
    tab_raddr = idx;
    tab_we    = 1'b0;
    tab_waddr = table_index;
    tab_wdata = char_value;
    dig_re    = 1'b0;
    dig_raddr = p;
    dig_we    = 1'b0;
    dig_waddr = p;
    dig_wdata = div_rsp.rem;
    div_req   = '{start: 1'b0, dividend: SUM_W'(carry - SUM_W'(1)), divisor: len};
    res       = '{push: 1'b0, ch: tab_rdata, pos: {1'b0, ei}, last: ei_last, ovf: 1'b0};
    unique case (state)
      ST_IDLE:     tab_we = cmd_fire && (opcode == OP_LOAD_CHAR);
      ST_SRCH_RD:  tab_re = 1'b1;
      ST_FILL: begin
        dig_we    = (fill < start);
        dig_waddr = fill[POS_W-1:0];
        dig_wdata = '0;
      end
      ST_WR: begin
        dig_we    = 1'b1;
        dig_waddr = pos_l;
        dig_wdata = found;
      end
      ST_GEN_CHK: begin
        dig_re        = !p_empty;
        div_req.start = p_empty && (carry != '0);
      end
      ST_GEN_SUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = SUM_W'(dig_rdata) + carry;
      end
      ST_GEN_DIV:  dig_we = div_rsp.done;
      ST_EMIT_DIG: begin
        dig_re    = 1'b1;
        dig_raddr = ei;
      end
      ST_EMIT_TAB: begin
        tab_re    = 1'b1;
        tab_raddr = dig_rdata;
      end
      ST_EMIT_OUT: res.push = slot_free;
      ST_ONE_OUT: begin
        res.push = slot_free;
        res.ch   = '0;
        res.pos  = ovf_flag ? '0 : SPOS_W'(MAX_LEN);
        res.last = 1'b1;
        res.ovf  = ovf_flag;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start <= SPOS_W'(MAX_LEN);
    end else begin
      state <= state_next;
      if (state == ST_IDLE && cmd_fire && opcode == OP_CLEAR) start <= SPOS_W'(MAX_LEN);
      if (state == ST_WR && {1'b0, pos_l} < start) start <= {1'b0, pos_l};
      if (state == ST_GEN_CHK && p_empty && carry != '0) start <= {1'b0, p};
    end
  end

  // Working registers; no two memory accesses of one item overlap
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx      <= '0;
        found    <= '0;
        pos_l    <= digit_position;
        ch_l     <= char_value;
        fill     <= SPOS_W'(digit_position) + SPOS_W'(1);
        p        <= POS_W'(MAX_LEN - 1);
        carry    <= SUM_W'(step_size);
        ovf_flag <= 1'b0;
      end
      ST_SRCH_CMP: begin
        if (srch_hit) found <= idx;
        idx <= idx + TAB_AW'(1);
      end
      ST_FILL:       if (fill < start) fill <= fill + SPOS_W'(1);
      ST_GEN_DIV: begin
        if (div_rsp.done) begin
          carry <= div_rsp.quot;
          if (div_rsp.quot != '0) begin
            if (p == '0) ovf_flag <= 1'b1;
            else         p <= p - POS_W'(1);
          end
        end
      end
      ST_EMIT_BEGIN: ei <= start[POS_W-1:0];
      ST_EMIT_OUT:   if (slot_free) ei <= ei + POS_W'(1);
      default: ;
    endcase
  end

endmodule

>>> src/pcc_checker.sv
`include "assert_macros.svh"

module pcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] out_char,
  input logic [4:0] out_position,
  input logic       last,
  input logic       overflow
);

  // A stalled result holds its character and position
  `CHK_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(out_char) && $stable(out_position), "result changed while stalled")

  // Overflow is a lone result at position 0 with no character
  `CHK_ASSERT(a_ovf_form, clk, rst, res_valid && overflow |-> last && out_position == 5'd0 && out_char == 8'd0, "bad overflow result")

  // Empty password result
  `CHK_ASSERT(a_empty_form, clk, rst, res_valid && out_position == 5'd16 |-> last && !overflow && out_char == 8'd0, "bad empty result")

  // Character results end at the rightmost position
  `CHK_ASSERT(a_last_pos, clk, rst, res_valid && !overflow && out_position != 5'd16 |-> last == (out_position == 5'd15), "last flag misplaced")

  // Nothing pending straight out of reset
  `CHK_ASSERT(a_reset_empty, clk, rst, $fell(rst) |-> !res_valid, "result valid after reset")

endmodule

bind password_candidate_counter pcc_checker u_pcc_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .out_char     (out_char),
  .out_position (out_position),
  .last         (last),
  .overflow     (overflow)
);
